@@ hw/rtl/fsts_pkg.sv @@
// Package for the final-state table sampler: constants, opcodes, status codes
// and the controller/datapath command and status structs. No dependencies.
package fsts_pkg;
  localparam int MaxStates = 64;
  localparam int IdxBits = 6;
  localparam int CountBits = 8;
  localparam int NumBits = 7;
  localparam int OffBits = 14;
  localparam int WeightBits = 32;
  localparam int DivCycles = 56;

  localparam logic [1:0] OpLoad = 2'd0;
  localparam logic [1:0] OpNorm = 2'd1;
  localparam logic [1:0] OpSample = 2'd2;
  localparam logic [1:0] OpGet = 2'd3;

  localparam logic [1:0] StChosen = 2'd0;
  localparam logic [1:0] StStopped = 2'd1;
  localparam logic [1:0] StAlive = 2'd2;
  localparam logic [1:0] StNormDone = 2'd3;

  typedef struct packed {
    logic load;
    logic cap_in;
    logic clr_acc;
    logic rd;
    logic [IdxBits-1:0] addr;
    logic cnt_acc;
    logic off_acc;
    logic run_acc;
    logic run_wr;
    logic cap_total;
    logic div_start;
    logic div_wr;
    logic emit_entry;
    logic emit_empty;
    logic emit_norm;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic total_zero;
    logic hit;
    logic div_done;
  } dp_stat_t;
endpackage

@@ hw/rtl/fsts_if.sv @@
// Valid/ready channel interfaces for the sampler input and result.
// Field widths are written as literals; no dependency on fsts_pkg.
interface fsts_in_if;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [5:0] state_index;
  logic [23:0] entry_weight;
  logic [7:0] entry_count;
  logic signed [31:0] entry_deposit;
  logic signed [31:0] entry_energy;
  logic entry_survives;
  logic [23:0] random_value;
  logic signed [31:0] primary_energy;
  modport source(output valid, opcode, state_index, entry_weight, entry_count,
    entry_deposit, entry_energy, entry_survives, random_value, primary_energy,
    input ready);
  modport sink(input valid, opcode, state_index, entry_weight, entry_count,
    entry_deposit, entry_energy, entry_survives, random_value, primary_energy,
    output ready);
endinterface

interface fsts_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic survives;
  logic [7:0] secondary_count;
  logic [31:0] chosen_weight;
  logic signed [31:0] chosen_deposit;
  logic signed [31:0] chosen_energy;
  logic [13:0] secondary_offset;
  logic [5:0] chosen_index;
  modport source(output valid, status, survives, secondary_count, chosen_weight,
    chosen_deposit, chosen_energy, secondary_offset, chosen_index, input ready);
  modport sink(input valid, status, survives, secondary_count, chosen_weight,
    chosen_deposit, chosen_energy, secondary_offset, chosen_index, output ready);
endinterface

@@ hw/rtl/final_state_table_sampler.sv @@
// Final-state table sampler: one transaction at a time. Load writes the entry
// memories when it is accepted. Sample walks the entry memory address by address
// for the search and then for the count prefix sum; get does only the prefix sum.
// Normalize sums the counts, forms the running weight sums and then divides each
// entry with the bit-serial divider. Result is held in an output register.
// Depends on fsts_pkg, fsts_if, fsts_ctrl and fsts_datapath.
module final_state_table_sampler (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [6:0] cfg_wdata,
  fsts_in_if.sink in_ch,
  fsts_out_if.source out_ch
);
  import fsts_pkg::*;
  logic [NumBits-1:0] num_states;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= '0;
    end else if (cfg_we) begin
      num_states <= cfg_wdata;
    end
  end

  assign out_fire = out_ch.valid && out_ch.ready;

  fsts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .opcode(in_ch.opcode),
    .state_index(in_ch.state_index), .num_states(num_states), .stat(stat),
    .out_busy(out_ch.valid), .in_ready(in_ch.ready), .cmd(cmd)
  );

  fsts_datapath u_dp (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cmd(cmd), .out_fire(out_fire),
    .stat(stat), .out_ch(out_ch)
  );
endmodule

@@ hw/rtl/fsts_div.sv @@
// Restoring divider: floor((num << 24) / den), one quotient bit per cycle.
// Depends on fsts_pkg.
module fsts_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic done,
  output logic [31:0] quo
);
  import fsts_pkg::*;
  logic [55:0] dvd;
  logic [32:0] rem;
  logic [5:0] cnt;
  logic busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], dvd[55]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'(DivCycles - 1);
        dvd <= {num, 24'd0};
        rem <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          dvd <= {dvd[54:0], 1'b1};
        end else begin
          rem <= {rem[31:0], dvd[55]};
          dvd <= {dvd[54:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end
  assign quo = dvd[31:0];
endmodule

@@ hw/rtl/fsts_datapath.sv @@
// Datapath of the sampler: entry memories, accumulators, divider and result
// register. Depends on fsts_pkg, fsts_if and fsts_div.
module fsts_datapath (
  input  logic clk,
  input  logic rst,
  fsts_in_if.sink in_ch,
  input  fsts_pkg::dp_cmd_t cmd,
  input  logic out_fire,
  output fsts_pkg::dp_stat_t stat,
  fsts_out_if.source out_ch
);
  import fsts_pkg::*;
  logic [31:0] w_mem [MaxStates];
  logic [CountBits-1:0] c_mem [MaxStates];
  logic [31:0] d_mem [MaxStates];
  logic [31:0] e_mem [MaxStates];
  logic s_mem [MaxStates];
  logic [31:0] w_rd, d_rd, e_rd;
  logic [CountBits-1:0] c_rd;
  logic s_rd;
  logic [IdxBits-1:0] rd_addr;
  logic [15:0] cnt_sum;
  logic [OffBits-1:0] off;
  logic [31:0] run, total;
  logic [32:0] run_sum;
  logic [23:0] rnd;
  logic [31:0] pe;
  logic div_done;
  logic [31:0] quo;
  logic out_load;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_mem[in_ch.state_index] <= {8'd0, in_ch.entry_weight};
      c_mem[in_ch.state_index] <= in_ch.entry_count;
      d_mem[in_ch.state_index] <= in_ch.entry_deposit;
      e_mem[in_ch.state_index] <= in_ch.entry_energy;
      s_mem[in_ch.state_index] <= in_ch.entry_survives;
    end else if (cmd.run_wr) begin
      w_mem[rd_addr] <= run_sum[32] ? 32'hFFFF_FFFF : run_sum[31:0];
    end else if (cmd.div_wr) begin
      w_mem[rd_addr] <= quo;
    end
    if (cmd.rd) begin
      rd_addr <= cmd.addr;
      w_rd <= w_mem[cmd.addr];
      c_rd <= c_mem[cmd.addr];
      d_rd <= d_mem[cmd.addr];
      e_rd <= e_mem[cmd.addr];
      s_rd <= s_mem[cmd.addr];
    end
  end

  assign run_sum = {1'b0, run} + {1'b0, w_rd};

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      rnd <= in_ch.random_value;
      pe <= in_ch.primary_energy;
    end
    if (cmd.clr_acc) begin
      cnt_sum <= '0;
      off <= '0;
      run <= '0;
    end else begin
      if (cmd.cnt_acc) cnt_sum <= cnt_sum + 16'(c_rd);
      if (cmd.off_acc)
        off <= (15'(off) + 15'(c_rd) > 15'h3FFF) ? 14'h3FFF : off + 14'(c_rd);
      if (cmd.run_acc) run <= run_sum[32] ? 32'hFFFF_FFFF : run_sum[31:0];
    end
    if (cmd.cap_total) total <= run_sum[32] ? 32'hFFFF_FFFF : run_sum[31:0];
  end

  fsts_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(w_rd), .den(total),
    .done(div_done), .quo(quo)
  );

  assign stat.cnt_zero = (cnt_sum == '0);
  assign stat.total_zero = (total == '0);
  assign stat.hit = ({8'd0, rnd} < w_rd);
  assign stat.div_done = div_done;

  assign out_load = cmd.emit_entry | cmd.emit_empty | cmd.emit_norm;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_fire) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_entry) begin
      out_ch.status <= StChosen;
      out_ch.survives <= s_rd;
      out_ch.secondary_count <= c_rd;
      out_ch.chosen_weight <= w_rd;
      out_ch.chosen_deposit <= d_rd;
      out_ch.chosen_energy <= e_rd;
      out_ch.secondary_offset <= off;
      out_ch.chosen_index <= rd_addr;
    end else if (cmd.emit_empty || cmd.emit_norm) begin
      if (cmd.emit_norm) begin
        out_ch.status <= StNormDone;
        out_ch.survives <= 1'b0;
      end else begin
        out_ch.status <= (pe != 0 && !pe[31]) ? StAlive : StStopped;
        out_ch.survives <= (pe != 0 && !pe[31]);
      end
      out_ch.secondary_count <= '0;
      out_ch.chosen_weight <= '0;
      out_ch.chosen_deposit <= '0;
      out_ch.chosen_energy <= '0;
      out_ch.secondary_offset <= '0;
      out_ch.chosen_index <= '0;
    end
  end
endmodule

@@ hw/rtl/fsts_ctrl.sv @@
// Controller of the sampler: sequences load, normalize, sample and get over
// the datapath. Depends on fsts_pkg.
module fsts_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [1:0] opcode,
  input  logic [5:0] state_index,
  input  logic [6:0] num_states,
  input  fsts_pkg::dp_stat_t stat,
  input  logic out_busy,
  output logic in_ready,
  output fsts_pkg::dp_cmd_t cmd
);
  import fsts_pkg::*;
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CNT   = 11'b00000000010,
    S_RUN   = 11'b00000000100,
    S_DIVRD = 11'b00000001000,
    S_DIVGO = 11'b00000010000,
    S_DIVWT = 11'b00000100000,
    S_SRCH  = 11'b00001000000,
    S_OFF   = 11'b00010000000,
    S_EMIT  = 11'b00100000000,
    S_NDONE = 11'b01000000000,
    S_EMPTY = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [NumBits-1:0] n, i, i_next, tgt, tgt_next;
  logic [1:0] op, op_next;
  logic ph, ph_next;
  logic [IdxBits-1:0] last;

  assign n = (num_states > 7'(MaxStates)) ? 7'(MaxStates) : num_states;
  assign last = IdxBits'(n - 7'd1);
  assign in_ready = (state == S_IDLE) && !out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i <= '0;
      tgt <= '0;
      op <= OpLoad;
      ph <= 1'b0;
    end else begin
      state <= state_next;
      i <= i_next;
      tgt <= tgt_next;
      op <= op_next;
      ph <= ph_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next = i;
    tgt_next = tgt;
    op_next = op;
    ph_next = ph;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.cap_in = 1'b1;
          cmd.clr_acc = 1'b1;
          op_next = opcode;
          i_next = '0;
          ph_next = 1'b0;
          case (opcode)
            OpLoad: cmd.load = 1'b1;
            OpNorm: state_next = (n == '0) ? S_NDONE : S_CNT;
            OpSample: state_next = (n == '0) ? S_EMPTY : S_SRCH;
            default: begin
              if (n == '0) begin
                state_next = S_EMPTY;
              end else begin
                tgt_next = (7'(state_index) < n) ? 7'(state_index) : n - 7'd1;
                state_next = S_OFF;
              end
            end
          endcase
        end
      end
      S_CNT: begin
        cmd.cnt_acc = ph;
        if (i < n) begin
          cmd.rd = 1'b1;
          cmd.addr = IdxBits'(i);
          i_next = i + 7'd1;
          ph_next = 1'b1;
        end else if (ph) begin
          ph_next = 1'b0;
        end else begin
          i_next = '0;
          state_next = stat.cnt_zero ? S_NDONE : S_RUN;
        end
      end
      S_RUN: begin
        if (!ph) begin
          cmd.rd = 1'b1;
          cmd.addr = IdxBits'(i);
          ph_next = 1'b1;
        end else begin
          cmd.run_acc = 1'b1;
          cmd.run_wr = 1'b1;
          ph_next = 1'b0;
          if (IdxBits'(i) == last) begin
            cmd.cap_total = 1'b1;
            i_next = '0;
            state_next = S_DIVRD;
          end else begin
            i_next = i + 7'd1;
          end
        end
      end
      S_DIVRD: begin
        if (stat.total_zero) begin
          state_next = S_NDONE;
        end else begin
          cmd.rd = 1'b1;
          cmd.addr = IdxBits'(i);
          state_next = S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next = S_DIVWT;
      end
      S_DIVWT: begin
        if (stat.div_done) begin
          cmd.div_wr = 1'b1;
          if (IdxBits'(i) == last) begin
            state_next = S_NDONE;
          end else begin
            i_next = i + 7'd1;
            state_next = S_DIVRD;
          end
        end
      end
      S_SRCH: begin
        if (!ph) begin
          cmd.rd = 1'b1;
          cmd.addr = IdxBits'(i);
          ph_next = 1'b1;
        end else begin
          ph_next = 1'b0;
          if (stat.hit || IdxBits'(i) == last) begin
            tgt_next = i;
            i_next = '0;
            state_next = S_OFF;
          end else begin
            i_next = i + 7'd1;
          end
        end
      end
      S_OFF: begin
        cmd.rd = 1'b1;
        cmd.addr = IdxBits'(i);
        cmd.off_acc = ph;
        ph_next = 1'b1;
        if (i == tgt) begin
          state_next = S_EMIT;
        end else begin
          i_next = i + 7'd1;
        end
      end
      S_EMIT: begin
        cmd.off_acc = 1'b0;
        cmd.emit_entry = 1'b1;
        ph_next = 1'b0;
        state_next = S_IDLE;
      end
      S_NDONE: begin
        cmd.emit_norm = 1'b1;
        state_next = S_IDLE;
      end
      S_EMPTY: begin
        cmd.emit_empty = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_emit_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_entry, cmd.emit_empty, cmd.emit_norm}))
    else $error("two results at once");
  a_no_emit_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_entry || cmd.emit_norm || cmd.emit_empty) |-> !out_busy)
    else $error("result overwritten");
endmodule
